### src/yfd_pkg.sv
package yfd_pkg;

  localparam int REG_W      = 13;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int BYTE_W     = 8;

  typedef enum logic [1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1,
    REG_TGT_W = 2'd2,
    REG_TGT_H = 2'd3
  } yfd_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] kept_byte;
    logic              frame_last;
    logic              size_error;
  } yfd_result_t;

  typedef struct packed {
    logic        hit;
    yfd_result_t res;
  } yfd_hit_t;

endpackage

### src/yfd_if.sv
interface yfd_in_if import yfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] source_byte;

  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

interface yfd_out_if import yfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] kept_byte;
  logic              frame_last;
  logic              size_error;

  modport source (output valid, output kept_byte, output frame_last, output size_error,
                  input ready);
  modport sink (input valid, input kept_byte, input frame_last, input size_error,
                output ready);
endinterface

### src/yfd_div.sv
module yfd_div #(
  parameter int W = 14
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W:0]       rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [W:0]       shifted;
  logic [W:0]       diff;

  // One quotient bit per cycle, restoring.
  always_comb begin
    shifted  = {rem_r[W-1:0], quo_r[W-1]};
    diff     = shifted - {1'b0, divisor};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNT_W'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = diff[W] ? shifted : diff;
      quo_nxt = {quo_r[W-2:0], ~diff[W]};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### src/yfd_scan.sv
module yfd_scan import yfd_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  take,
  input  logic [BYTE_W-1:0]                     source_byte,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        cur_sw,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]       cur_sh,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        cur_tw,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]       cur_th,
  input  logic [((($clog2(MAX_WIDTH+1)) > ($clog2(MAX_HEIGHT+1))) ?
                 $clog2(MAX_WIDTH+1) : $clog2(MAX_HEIGHT+1))-1:0] cur_s,
  input  logic                                  cur_err,
  output yfd_hit_t                              hit
);

  localparam int SWW = $clog2(MAX_WIDTH + 1);
  localparam int SHW = $clog2(MAX_HEIGHT + 1);
  localparam int DW  = (SWW > SHW) ? SWW : SHW;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int PW  = CW + 1;

  // position state
  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic           chroma_r, chroma_nxt;
  logic [DW-1:0]  cph_r, cph_nxt;
  logic [CW-1:0]  cquot_r, cquot_nxt;
  logic [DW-1:0]  pph_r, pph_nxt;
  logic [CW-1:0]  pquot_r, pquot_nxt;
  logic [DW-1:0]  rph_r, rph_nxt;
  logic [RW-1:0]  rquot_r, rquot_nxt;

  // frame sizes held for the running frame
  logic [SWW-1:0] lat_sw_r, lat_tw_r;
  logic [SHW-1:0] lat_sh_r, lat_th_r;
  logic [DW-1:0]  lat_s_r;
  logic           lat_err_r;

  logic           fstart;
  logic [SWW-1:0] e_sw, e_tw;
  logic [SHW-1:0] e_sh, e_th;
  logic [DW-1:0]  e_s;
  logic           e_err;
  logic [SWW-1:0] col_inc;
  logic [SHW-1:0] row_inc, row_lim;
  logic           col_wrap, row_wrap;
  logic [PW-1:0]  dcol;
  logic           luma_keep, chroma_keep, chroma_last, err_hit;

  always_comb begin
    fstart  = (col_r == '0) && (row_r == '0) && !chroma_r;
    e_sw    = fstart ? cur_sw  : lat_sw_r;
    e_sh    = fstart ? cur_sh  : lat_sh_r;
    e_tw    = fstart ? cur_tw  : lat_tw_r;
    e_th    = fstart ? cur_th  : lat_th_r;
    e_s     = fstart ? cur_s   : lat_s_r;
    e_err   = fstart ? cur_err : lat_err_r;

    col_inc  = SWW'(col_r) + SWW'(1);
    col_wrap = (col_inc >= e_sw);
    row_inc  = SHW'(row_r) + SHW'(1);
    row_lim  = chroma_r ? (e_sh >> 1) : e_sh;
    row_wrap = (row_inc >= row_lim);

    dcol = {pquot_r, col_r[0]};

    luma_keep   = (rph_r == '0) && (cph_r == '0) &&
                  (SHW'(rquot_r) < e_th) && (SWW'(cquot_r) < e_tw);
    chroma_keep = (rph_r == '0) && (pph_r == '0) &&
                  (SHW'(rquot_r) < (e_th >> 1)) && (dcol < PW'(e_tw));
    chroma_last = (SHW'(rquot_r) + SHW'(1) == (e_th >> 1)) &&
                  (dcol + PW'(1) == PW'(e_tw));
    err_hit     = chroma_r && (row_inc == (e_sh >> 1)) && (col_inc == e_sw);

    hit.hit              = e_err ? err_hit : (chroma_r ? chroma_keep : luma_keep);
    hit.res.kept_byte    = e_err ? '0 : source_byte;
    hit.res.frame_last   = e_err ? 1'b1 : (chroma_r && chroma_last);
    hit.res.size_error   = e_err;
  end

  // Advance the raster position and the phase/quotient counters that stand in
  // for the divisions by scale.
  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    chroma_nxt = chroma_r;
    cph_nxt    = cph_r;
    cquot_nxt  = cquot_r;
    pph_nxt    = pph_r;
    pquot_nxt  = pquot_r;
    rph_nxt    = rph_r;
    rquot_nxt  = rquot_r;
    if (take) begin
      if (col_wrap) begin
        col_nxt   = '0;
        cph_nxt   = '0;
        cquot_nxt = '0;
        pph_nxt   = '0;
        pquot_nxt = '0;
        if (row_wrap) begin
          row_nxt    = '0;
          rph_nxt    = '0;
          rquot_nxt  = '0;
          chroma_nxt = !chroma_r;
        end else begin
          row_nxt = RW'(row_inc);
          if (rph_r + DW'(1) == e_s) begin
            rph_nxt   = '0;
            rquot_nxt = rquot_r + RW'(1);
          end else begin
            rph_nxt = rph_r + DW'(1);
          end
        end
      end else begin
        col_nxt = CW'(col_inc);
        if (cph_r + DW'(1) == e_s) begin
          cph_nxt   = '0;
          cquot_nxt = cquot_r + CW'(1);
        end else begin
          cph_nxt = cph_r + DW'(1);
        end
        // the pair index moves after the second byte of each pair
        if (col_r[0]) begin
          if (pph_r + DW'(1) == e_s) begin
            pph_nxt   = '0;
            pquot_nxt = pquot_r + CW'(1);
          end else begin
            pph_nxt = pph_r + DW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      chroma_r <= 1'b0;
      cph_r    <= '0;
      cquot_r  <= '0;
      pph_r    <= '0;
      pquot_r  <= '0;
      rph_r    <= '0;
      rquot_r  <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      chroma_r <= chroma_nxt;
      cph_r    <= cph_nxt;
      cquot_r  <= cquot_nxt;
      pph_r    <= pph_nxt;
      pquot_r  <= pquot_nxt;
      rph_r    <= rph_nxt;
      rquot_r  <= rquot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && fstart) begin
      lat_sw_r  <= cur_sw;
      lat_sh_r  <= cur_sh;
      lat_tw_r  <= cur_tw;
      lat_th_r  <= cur_th;
      lat_s_r   <= cur_s;
      lat_err_r <= cur_err;
    end
  end

endmodule

### src/yfd_out.sv
module yfd_out import yfd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  yfd_hit_t         hit,
  output logic             free,
  yfd_out_if.source        out_chan
);

  logic        valid_r, valid_nxt;
  yfd_result_t data_r, data_nxt;

  assign free = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (take && hit.hit) begin
      valid_nxt = 1'b1;
      data_nxt  = hit.res;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_chan.valid      = valid_r;
  assign out_chan.kept_byte  = data_r.kept_byte;
  assign out_chan.frame_last = data_r.frame_last;
  assign out_chan.size_error = data_r.size_error;

endmodule

### src/yuv420sp_frame_decimator_unit.sv
// channel   | dir | handshake            | payload
// in_chan   | in  | valid/ready          | source_byte[7:0]
// out_chan  | out | valid/ready          | kept_byte[7:0], frame_last, size_error
// cfg (APB) | in  | psel/penable, pready | paddr[3:0], pwdata[31:0], prdata[31:0]
//
// One source byte per clock while in_chan.ready is high; a kept byte shows on out_chan in the cycle after it is taken.
// Each register write (and reset) reruns the scale divide, during which
//   in_chan.ready stays low.
// Reset (rst_n, synchronous) returns to row 0, column 0 of the luma plane.
// A stalled out_chan holds its item; in_chan keeps flowing while the output
//   register is empty or being drained in the same cycle.
module yuv420sp_frame_decimator_unit import yfd_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  yfd_in_if.sink                in_chan,
  yfd_out_if.source             out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SWW = $clog2(MAX_WIDTH + 1);
  localparam int SHW = $clog2(MAX_HEIGHT + 1);
  localparam int DW  = (SWW > SHW) ? SWW : SHW;
  localparam int CLW = REG_W + 2;
  localparam logic [CLW-1:0] MAXW_C = CLW'(MAX_WIDTH);
  localparam logic [CLW-1:0] MAXH_C = CLW'(MAX_HEIGHT);

  logic [REG_W-1:0] src_w_r, src_h_r, tgt_w_r, tgt_h_r;
  logic             cfg_wr;
  logic             start_r;
  logic             scale_ok_r, scale_ok_nxt;
  logic [DW-1:0]    scale_r;
  logic [SWW-1:0]   cur_sw, cur_tw;
  logic [SHW-1:0]   cur_sh, cur_th;
  logic             cur_err;
  logic             dx_done, dy_done;
  logic [DW-1:0]    qx, qy;
  logic             take, out_free;
  yfd_hit_t         hit;

  // Sizes below 2 act as 2, above the limit act as the limit.
  function automatic logic [CLW-1:0] clamp_dim(input logic [REG_W-1:0] v,
                                               input logic [CLW-1:0]   maxv);
    logic [CLW-1:0] ext;
    ext = CLW'(v);
    if (ext < CLW'(2)) begin
      return CLW'(2);
    end else if (ext > maxv) begin
      return maxv;
    end
    return ext;
  endfunction

  always_comb begin
    cur_sw  = SWW'(clamp_dim(src_w_r, MAXW_C));
    cur_sh  = SHW'(clamp_dim(src_h_r, MAXH_C));
    cur_tw  = SWW'(clamp_dim(tgt_w_r, MAXW_C));
    cur_th  = SHW'(clamp_dim(tgt_h_r, MAXH_C));
    cur_err = (cur_tw > cur_sw) || (cur_th > cur_sh);
  end

  // Configuration registers: write on the APB access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= REG_W'(640);
      src_h_r <= REG_W'(480);
      tgt_w_r <= REG_W'(160);
      tgt_h_r <= REG_W'(120);
    end else if (cfg_wr) begin
      case (yfd_reg_t'(paddr[3:2]))
        REG_SRC_W: src_w_r <= pwdata[REG_W-1:0];
        REG_SRC_H: src_h_r <= pwdata[REG_W-1:0];
        REG_TGT_W: tgt_w_r <= pwdata[REG_W-1:0];
        REG_TGT_H: tgt_h_r <= pwdata[REG_W-1:0];
        default:   src_w_r <= src_w_r;
      endcase
    end
  end

  always_comb begin
    case (yfd_reg_t'(paddr[3:2]))
      REG_SRC_W: prdata = CFG_DATA_W'(src_w_r);
      REG_SRC_H: prdata = CFG_DATA_W'(src_h_r);
      REG_TGT_W: prdata = CFG_DATA_W'(tgt_w_r);
      REG_TGT_H: prdata = CFG_DATA_W'(tgt_h_r);
      default:   prdata = '0;
    endcase
  end

  // Scale = sw/tw when it matches sh/th and is nonzero, else 1. Both quotients run in
  // lockstep; a new write restarts them and drops the ready scale.
  yfd_div #(.W(DW)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (DW'(cur_sw)),
    .divisor  (DW'(cur_tw)),
    .done     (dx_done),
    .quotient (qx)
  );

  yfd_div #(.W(DW)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (DW'(cur_sh)),
    .divisor  (DW'(cur_th)),
    .done     (dy_done),
    .quotient (qy)
  );

  always_comb begin
    scale_ok_nxt = scale_ok_r;
    if (cfg_wr) begin
      scale_ok_nxt = 1'b0;
    end else if (dx_done && dy_done && !start_r) begin
      // ignore a finish that a newer write has already overtaken
      scale_ok_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r    <= 1'b1;
      scale_ok_r <= 1'b0;
    end else begin
      start_r    <= cfg_wr;
      scale_ok_r <= scale_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dx_done) begin
      scale_r <= ((qx == qy) && (qx != '0)) ? qx : DW'(1);
    end
  end

  // Accept a byte whenever the scale is settled and the output slot frees up.
  assign in_chan.ready = scale_ok_r && out_free;
  assign take          = in_chan.valid && in_chan.ready;

  yfd_scan #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .source_byte (in_chan.source_byte),
    .cur_sw      (cur_sw),
    .cur_sh      (cur_sh),
    .cur_tw      (cur_tw),
    .cur_th      (cur_th),
    .cur_s       (scale_r),
    .cur_err     (cur_err),
    .hit         (hit)
  );

  yfd_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .hit      (hit),
    .free     (out_free),
    .out_chan (out_chan)
  );

  a_no_take_unsettled: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> scale_ok_r)
    else $error("byte taken while scale not settled");

  a_write_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> !in_chan.ready)
    else $error("input ready right after a register write");

  a_error_item_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.size_error |->
      out_chan.frame_last && (out_chan.kept_byte == '0))
    else $error("malformed size error item");

  a_done_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    dx_done == dy_done)
    else $error("scale dividers out of step");

endmodule

### verif/yfd_decimation_checker.sv
`timescale 1ns / 100ps
module yfd_decimation_checker import yfd_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  yfd_in_if                     in_mon,
  yfd_out_if                    out_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    fail_count,
  output int                    outstanding
);

  localparam logic [REG_W-1:0] RESET_SRC_W = 640;
  localparam logic [REG_W-1:0] RESET_SRC_H = 480;
  localparam logic [REG_W-1:0] RESET_TGT_W = 160;
  localparam logic [REG_W-1:0] RESET_TGT_H = 120;

  logic [REG_W-1:0] size_reg [4];
  // sizes and scale frozen at the first byte of a frame
  logic [REG_W-1:0] src_w, src_h, tgt_w, tgt_h;
  logic [REG_W-1:0] scale;
  logic             bad_size;
  logic [REG_W-1:0] row_pos;
  logic [REG_W-1:0] col_pos;
  logic             in_chroma;
  yfd_result_t      kept_q [$];
  int               fails = 0;

  function automatic logic [REG_W-1:0] clamp_size(logic [REG_W-1:0] v, int unsigned lim);
    if (v < 2) return REG_W'(2);
    if (v > lim) return REG_W'(lim);
    return v;
  endfunction

  task automatic latch_frame();
    int unsigned sx, sy;
    src_w = clamp_size(size_reg[REG_SRC_W], MAX_WIDTH);
    src_h = clamp_size(size_reg[REG_SRC_H], MAX_HEIGHT);
    tgt_w = clamp_size(size_reg[REG_TGT_W], MAX_WIDTH);
    tgt_h = clamp_size(size_reg[REG_TGT_H], MAX_HEIGHT);
    sx = src_w / tgt_w;
    sy = src_h / tgt_h;
    bad_size = (tgt_w > src_w) || (tgt_h > src_h);
    scale = (sx == sy && sx != 0) ? REG_W'(sx) : REG_W'(1);
  endtask

  // Work out what one source byte yields, then advance the raster position.
  task automatic take_byte(logic [BYTE_W-1:0] b);
    int unsigned r, c, s, pair, dcol;
    bit          keep, last, err;
    yfd_result_t res;
    keep = 1'b0;
    last = 1'b0;
    err  = 1'b0;
    if (row_pos == 0 && col_pos == 0 && !in_chroma) latch_frame();
    r = row_pos;
    c = col_pos;
    s = scale;
    pair = c >> 1;
    dcol = 2 * (pair / s) + (c & 1);
    if (bad_size) begin
      err = in_chroma && (r == src_h / 2 - 1) && (c == src_w - 1);
    end else if (!in_chroma) begin
      keep = (r % s == 0) && (c % s == 0) && (r / s < tgt_h) && (c / s < tgt_w);
    end else begin
      keep = (r % s == 0) && (pair % s == 0) && (r / s < tgt_h / 2) && (dcol < tgt_w);
      last = keep && (r / s == tgt_h / 2 - 1) && (dcol == tgt_w - 1);
    end

    if (c + 1 >= src_w) begin
      col_pos = '0;
      if (!in_chroma && r + 1 >= src_h) begin
        row_pos   = '0;
        in_chroma = 1'b1;
      end else if (in_chroma && r + 1 >= src_h / 2) begin
        row_pos   = '0;
        in_chroma = 1'b0;
      end else begin
        row_pos = REG_W'(r + 1);
      end
    end else begin
      col_pos = REG_W'(c + 1);
    end

    if (err) begin
      res.kept_byte  = '0;
      res.frame_last = 1'b1;
      res.size_error = 1'b1;
      kept_q.push_back(res);
    end else if (keep) begin
      res.kept_byte  = b;
      res.frame_last = last;
      res.size_error = 1'b0;
      kept_q.push_back(res);
    end
  endtask

  function automatic bit field_ok(string name, logic [BYTE_W-1:0] want,
                                  logic [BYTE_W-1:0] got);
    if (got === want) return 1'b1;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    return 1'b0;
  endfunction

  task automatic check_result();
    yfd_result_t want;
    bit          bad;
    if (kept_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kept_byte %0h last %0b err %0b",
               $time, out_mon.kept_byte, out_mon.frame_last, out_mon.size_error);
      fails++;
      return;
    end
    want = kept_q.pop_front();
    bad = !field_ok("kept_byte", want.kept_byte, out_mon.kept_byte)
        | !field_ok("frame_last", BYTE_W'(want.frame_last), BYTE_W'(out_mon.frame_last))
        | !field_ok("size_error", BYTE_W'(want.size_error), BYTE_W'(out_mon.size_error));
    if (bad) fails++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      size_reg[REG_SRC_W] = RESET_SRC_W;
      size_reg[REG_SRC_H] = RESET_SRC_H;
      size_reg[REG_TGT_W] = RESET_TGT_W;
      size_reg[REG_TGT_H] = RESET_TGT_H;
      row_pos   = '0;
      col_pos   = '0;
      in_chroma = 1'b0;
      latch_frame();
      kept_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) size_reg[paddr[3:2]] = pwdata[REG_W-1:0];
      // results trail their source byte, so drain before pushing
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready) take_byte(in_mon.source_byte);
    end
    fail_count  <= fails;
    outstanding <= kept_q.size();
  end

endmodule

### verif/yuv420sp_frame_decimator_unit_tb.sv
`timescale 1ns / 100ps
module yuv420sp_frame_decimator_unit_tb;
  import yfd_pkg::*;

  localparam int MAX_WIDTH       = 4096;
  localparam int MAX_HEIGHT      = 4096;
  localparam int RANDOM_ITEMS    = 400;
  // hold the result side off long enough to back the input up
  localparam int HOLD_OFF_CYCLES = 300;
  // covers the scale divide after a write, plus the output stage
  localparam int SETTLE_CYCLES   = 20;
  // longest legal quiet stretch is the hold-off plus a divide
  localparam int WATCHDOG_LIMIT  = 5000;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int               fail_count;
  int               outstanding;
  int               tx_idle_pct;
  int               rx_idle_pct;
  bit               hold_request = 1'b0;
  bit               hold_done = 1'b0;
  int               quiet_cycles = 0;
  // bytes still owed to the frame in progress, 0 at a frame boundary
  int               frame_left = 0;
  int               random_sent = 0;
  logic [REG_W-1:0] size_copy [4];

  yfd_in_if  in_chan ();
  yfd_out_if out_chan ();

  yuv420sp_frame_decimator_unit #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  yfd_decimation_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) decimation_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    int hold_left;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done && hold_left == 0) hold_left = HOLD_OFF_CYCLES;
      if (hold_left != 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
        if (hold_left == 0) hold_done = 1'b1;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: end the run if no item moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int clamped(logic [REG_W-1:0] v, int lim);
    return (v < 2) ? 2 : (v > lim) ? lim : int'(v);
  endfunction

  // Source bytes in one frame: luma plane plus half-height chroma plane.
  function automatic int frame_bytes();
    int w, h;
    w = clamped(size_copy[REG_SRC_W], MAX_WIDTH);
    h = clamped(size_copy[REG_SRC_H], MAX_HEIGHT);
    return w * h + w * (h / 2);
  endfunction

  task automatic set_idle(int tx, int rx);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
  endtask

  // Offer one item, idling first at random, and hold it until taken.
  task automatic send_byte(logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.source_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    // sizes are picked up by the block at the first byte of each frame
    if (frame_left == 0) frame_left = frame_bytes();
    frame_left--;
  endtask

  task automatic send_random(int n);
    repeat (n) send_byte(BYTE_W'($urandom_range(255)));
  endtask

  // Close the frame in progress, then send whole frames at the current sizes.
  task automatic send_frames(int frames);
    send_random(frame_left + frames * frame_bytes());
  endtask

  // Drop valid, wait for every expected result, then let the block settle.
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup then access; psel stays up so back-to-back writes chain cleanly.
  task automatic write_reg(yfd_reg_t idx, logic [REG_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(int'(idx) * 4);
    pwdata  <= CFG_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    size_copy[idx] = v;
  endtask

  task automatic write_sizes(logic [REG_W-1:0] sw, logic [REG_W-1:0] sh,
                             logic [REG_W-1:0] tw, logic [REG_W-1:0] th);
    wait_idle();
    write_reg(REG_SRC_W, sw);
    write_reg(REG_SRC_H, sh);
    write_reg(REG_TGT_W, tw);
    write_reg(REG_TGT_H, th);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [REG_W-1:0] sw, sh, tw, th;
    int               s, n;

    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.source_byte <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    set_idle(17, 51);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Size error with clamping: source width and height below 2 read as 2, target
    // height above the limit reads as the limit, so the frame is dropped and
    // one error item comes with its last chroma byte.
    write_sizes(1, 0, 2, 8191);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h01);
    send_byte(8'h80);

    // Odd source height (one chroma row), odd target width and height.
    write_sizes(4, 3, 3, 3);
    for (int i = 0; i < 16; i++)
      send_byte((i < 8) ? BYTE_W'(1 << i) : ~BYTE_W'(1 << (i - 8)));

    // Change sizes mid-frame: the old frame must finish at the old sizes.
    write_sizes(2, 2, 2, 2);
    send_random(3);
    write_sizes(4, 4, 2, 2);
    send_frames(0);

    // Wide rows, every byte kept; hold the result side off meanwhile.
    write_sizes(24, 4, 24, 4);
    hold_request = 1'b1;
    send_frames(1);

    // Tall frame, cropped to the minimum.
    write_sizes(1, 40, 0, 2);
    send_frames(1);

    // Random phases: mostly exact scale ratios, some crops, some odd or
    // illegal sizes. End some phases mid-frame.
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent < RANDOM_ITEMS / 3) set_idle(17, 51);
      else if (random_sent < 2 * RANDOM_ITEMS / 3) set_idle(51, 17);
      else set_idle(0, 0);
      case ($urandom_range(3))
        0, 1: begin
          s  = ($urandom_range(7) == 0) ? 4 : $urandom_range(1, 3);
          tw = REG_W'($urandom_range(2, 4));
          th = REG_W'($urandom_range(2, 4));
          sw = REG_W'(tw * s + $urandom_range(0, 1));
          sh = REG_W'(th * s + $urandom_range(0, 1));
        end
        2: begin
          sw = REG_W'($urandom_range(2, 12));
          sh = REG_W'($urandom_range(2, 12));
          tw = REG_W'($urandom_range(2, sw));
          th = REG_W'($urandom_range(2, sh));
        end
        default: begin
          sw = REG_W'($urandom_range(0, 8));
          sh = REG_W'($urandom_range(0, 8));
          tw = REG_W'($urandom_range(0, 10));
          th = REG_W'($urandom_range(0, 10));
        end
      endcase
      write_sizes(sw, sh, tw, th);
      n = frame_left + $urandom_range(1, 2) * frame_bytes();
      if ($urandom_range(3) == 0) n += $urandom_range(1, frame_bytes() - 1);
      // keep the total near the item budget; the last phase may stop mid-frame
      if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;
      send_random(n);
      random_sent += n;
    end

    wait_idle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
